[hw/rtl/iqr_pkg.sv]
// ----------------------------------------------------------------------------
// iqr_pkg
// Shared types and constants for the indexed queue with removal.
// ----------------------------------------------------------------------------
package iqr_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ENTRY_BITS  = 32;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // depth of the front-to-back command queue and of the result queue
  localparam int CMDQ_DEPTH  = 4;
  localparam int RESQ_DEPTH  = 4;
  localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_DROP_HEAD = 3'd2,
    OP_READ_AT   = 3'd3,
    OP_REMOVE_AT = 3'd4,
    OP_CLEAR     = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_READ,
    CMD_SHIFT
  } cmd_kind_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    cmd_kind_t kind;
    res_t      res;
  } cmd_ctl_t;

endpackage

[hw/rtl/indexed_queue_with_removal.sv]
// ----------------------------------------------------------------------------
// indexed_queue_with_removal
// Circular queue with push, pop, drop head, read at, remove at and clear.
// ----------------------------------------------------------------------------
// Requests enter on push/full with in_opcode, in_item_value and in_position;
// a request is taken when push is high and full is low. Every request gives
// exactly one result, in order, on out_ok, out_data_out and
// out_entry_count_now, shown while empty is low and taken with pop.
// The front checks each request against head and count at once and queues a
// command; the back owns the entry store and carries commands out in order.
// When the back is free, a taken request goes through the command queue and
// the back's output registers, and its result shows from the result queue.
// Push, pop, drop head, read at and clear run at one request per cycle while
// the result queue has room. Remove at moves each entry behind the removed
// one down a slot, one per cycle through the store's single write port, or
// none for the last entry; requests behind it wait in the command queue.
// When the receiver stalls, up to 4 results wait in the result queue, then
// the back holds and the 4-deep command queue fills and raises full.
// Reset empties both queues and sets head and count to zero; the entry store
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module indexed_queue_with_removal #(
  parameter int QUEUE_DEPTH = iqr_pkg::DEF_QUEUE_DEPTH,
  parameter int ENTRY_BITS  = iqr_pkg::DEF_ENTRY_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [iqr_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [iqr_pkg::VALUE_W-1:0]   in_item_value,
  input  logic [iqr_pkg::POS_W-1:0]     in_position,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_ok,
  output logic [iqr_pkg::VALUE_W-1:0]   out_data_out,
  output logic [iqr_pkg::COUNT_W-1:0]   out_entry_count_now
);

  import iqr_pkg::*;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CMD_W  = $bits(cmd_ctl_t) + ADDR_W + ENTRY_BITS + CNT_W;
  localparam int RES_W  = $bits(res_t) + ENTRY_BITS;
  localparam int XW     = (ENTRY_BITS > VALUE_W) ? ENTRY_BITS : VALUE_W;

  logic                   accept;
  cmd_ctl_t               f_ctl, b_ctl;
  logic [ADDR_W-1:0]      f_addr, b_addr;
  logic [ENTRY_BITS-1:0]  f_wdata, b_wdata;
  logic [CNT_W-1:0]       f_len, b_len;
  logic [CMD_W-1:0]       cmdq_rd;
  logic                   cmdq_empty, cmd_pop;
  logic [$clog2(CMDQ_DEPTH+1)-1:0] cmdq_cnt;

  logic                   res_push;
  res_t                   b_res, q_res;
  logic [ENTRY_BITS-1:0]  b_data, q_data;
  logic [RES_W-1:0]       resq_rd;
  logic                   resq_full;
  logic [RESQ_CNT_W-1:0]  resq_cnt;
  logic [XW-1:0]          data_ext;

  assign accept = push && !full;

  iqr_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_BITS  (ENTRY_BITS),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .opcode     (in_opcode),
    .item_value (in_item_value),
    .position   (in_position),
    .cmd_ctl    (f_ctl),
    .cmd_addr   (f_addr),
    .cmd_wdata  (f_wdata),
    .cmd_len    (f_len)
  );

  iqr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data ({f_ctl, f_addr, f_wdata, f_len}),
    .rd_en   (cmd_pop),
    .rd_data (cmdq_rd),
    .full    (full),
    .empty   (cmdq_empty),
    .count   (cmdq_cnt)
  );

  assign {b_ctl, b_addr, b_wdata, b_len} = cmdq_rd;

  iqr_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_BITS  (ENTRY_BITS),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmdq_empty),
    .cmd_ctl   (b_ctl),
    .cmd_addr  (b_addr),
    .cmd_wdata (b_wdata),
    .cmd_len   (b_len),
    .cmd_pop   (cmd_pop),
    .res_cnt   (resq_cnt),
    .res_push  (res_push),
    .res       (b_res),
    .res_data  (b_data)
  );

  // the back never pushes into a full result queue
  iqr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RESQ_DEPTH),
    .CNT_W (RESQ_CNT_W)
  ) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data ({b_res, b_data}),
    .rd_en   (pop),
    .rd_data (resq_rd),
    .full    (resq_full),
    .empty   (empty),
    .count   (resq_cnt)
  );

  assign {q_res, q_data} = resq_rd;
  assign data_ext = XW'(q_data);

  assign out_ok              = q_res.ok && !(resq_full && cmdq_cnt[0] && 1'b0);
  assign out_data_out        = data_ext[VALUE_W-1:0];
  assign out_entry_count_now = q_res.count;

endmodule

[hw/rtl/iqr_fifo.sv]
// ----------------------------------------------------------------------------
// iqr_fifo
// Small register queue with occupancy count, used between the block stages.
// ----------------------------------------------------------------------------
module iqr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_data = slots_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[hw/rtl/iqr_front.sv]
// ----------------------------------------------------------------------------
// iqr_front
// Holds head and count, checks each request and turns it into a command.
// ----------------------------------------------------------------------------
module iqr_front #(
  parameter int QUEUE_DEPTH = iqr_pkg::DEF_QUEUE_DEPTH,
  parameter int ENTRY_BITS  = iqr_pkg::DEF_ENTRY_BITS,
  parameter int ADDR_W      = $clog2(QUEUE_DEPTH),
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [iqr_pkg::OPCODE_W-1:0]  opcode,
  input  logic [iqr_pkg::VALUE_W-1:0]   item_value,
  input  logic [iqr_pkg::POS_W-1:0]     position,
  output iqr_pkg::cmd_ctl_t             cmd_ctl,
  output logic [ADDR_W-1:0]             cmd_addr,
  output logic [ENTRY_BITS-1:0]         cmd_wdata,
  output logic [CNT_W-1:0]              cmd_len
);

  import iqr_pkg::*;

  localparam int PW = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int XW = (ENTRY_BITS > VALUE_W) ? ENTRY_BITS : VALUE_W;

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pos_hit;
  logic [ADDR_W-1:0] pos_slot;
  logic [XW-1:0]     value_ext;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
      s = s - (ADDR_W+1)'(QUEUE_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  assign value_ext = XW'(item_value);
  assign cmd_wdata = value_ext[ENTRY_BITS-1:0];
  assign pos_hit   = PW'(position) < PW'(count_r);
  assign pos_slot  = slot_of(head_r, ADDR_W'(position));

  always_comb begin
    cmd_ctl.kind   = CMD_NONE;
    cmd_ctl.res.ok = 1'b0;
    cmd_addr       = pos_slot;
    cmd_len        = '0;
    head_nxt       = head_r;
    count_nxt      = count_r;
    case (opcode)
      OP_PUSH: begin
        if (count_r < CNT_W'(QUEUE_DEPTH)) begin
          cmd_ctl.kind   = CMD_WRITE;
          cmd_ctl.res.ok = 1'b1;
          cmd_addr       = slot_of(head_r, count_r[ADDR_W-1:0]);
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      OP_POP, OP_DROP_HEAD: begin
        if (count_r != '0) begin
          // drop head answers without touching the store
          cmd_ctl.kind   = (opcode == OP_POP) ? CMD_READ : CMD_NONE;
          cmd_ctl.res.ok = 1'b1;
          cmd_addr       = head_r;
          head_nxt       = slot_of(head_r, ADDR_W'(1));
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      OP_READ_AT: begin
        if (pos_hit) begin
          cmd_ctl.kind   = CMD_READ;
          cmd_ctl.res.ok = 1'b1;
        end
      end
      OP_REMOVE_AT: begin
        if (pos_hit) begin
          cmd_ctl.kind   = CMD_SHIFT;
          cmd_ctl.res.ok = 1'b1;
          cmd_len        = count_r - CNT_W'(position) - CNT_W'(1);
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        cmd_ctl.res.ok = 1'b1;
        head_nxt       = '0;
        count_nxt      = '0;
      end
      default: begin
      end
    endcase
    cmd_ctl.res.count = COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[hw/rtl/iqr_back.sv]
// ----------------------------------------------------------------------------
// iqr_back
// Entry store and sequencer: carries out writes, reads and remove shifts.
// ----------------------------------------------------------------------------
module iqr_back #(
  parameter int QUEUE_DEPTH = iqr_pkg::DEF_QUEUE_DEPTH,
  parameter int ENTRY_BITS  = iqr_pkg::DEF_ENTRY_BITS,
  parameter int ADDR_W      = $clog2(QUEUE_DEPTH),
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_empty,
  input  iqr_pkg::cmd_ctl_t               cmd_ctl,
  input  logic [ADDR_W-1:0]               cmd_addr,
  input  logic [ENTRY_BITS-1:0]           cmd_wdata,
  input  logic [CNT_W-1:0]                cmd_len,
  output logic                            cmd_pop,
  input  logic [iqr_pkg::RESQ_CNT_W-1:0]  res_cnt,
  output logic                            res_push,
  output iqr_pkg::res_t                   res,
  output logic [ENTRY_BITS-1:0]           res_data
);

  import iqr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_t;

  logic [ENTRY_BITS-1:0] store_mem [QUEUE_DEPTH];
  logic [ENTRY_BITS-1:0] mem_q_r;

  state_t            state_r, state_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  res_t              s1_res_r, s1_res_nxt;
  logic              s1_rd_r, s1_rd_nxt;
  res_t              sh_res_r, sh_res_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt, dst_r, dst_nxt;
  logic [CNT_W-1:0]  rd_left_r, rd_left_nxt, wr_left_r, wr_left_nxt;
  logic              pend_r, pend_nxt;

  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_wa, mem_ra;
  logic [ENTRY_BITS-1:0] mem_wd;
  logic                  space;

  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] s);
    return (s == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : s + ADDR_W'(1);
  endfunction

  // room in the result queue for everything already on its way
  assign space = ({1'b0, res_cnt} + (RESQ_CNT_W+1)'(s1_valid_r))
                 < (RESQ_CNT_W+1)'(RESQ_DEPTH);

  assign res_push = s1_valid_r;
  assign res      = s1_res_r;
  assign res_data = s1_rd_r ? mem_q_r : '0;

  always_comb begin
    state_nxt    = state_r;
    s1_valid_nxt = 1'b0;
    s1_res_nxt   = s1_res_r;
    s1_rd_nxt    = 1'b0;
    sh_res_nxt   = sh_res_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    rd_left_nxt  = rd_left_r;
    wr_left_nxt  = wr_left_r;
    pend_nxt     = 1'b0;
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = cmd_addr;
    mem_wd       = cmd_wdata;
    mem_re       = 1'b0;
    mem_ra       = cmd_addr;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty && space) begin
          cmd_pop    = 1'b1;
          s1_res_nxt = cmd_ctl.res;
          case (cmd_ctl.kind)
            CMD_WRITE: begin
              mem_we       = 1'b1;
              s1_valid_nxt = 1'b1;
            end
            CMD_READ: begin
              mem_re       = 1'b1;
              s1_valid_nxt = 1'b1;
              s1_rd_nxt    = 1'b1;
            end
            CMD_SHIFT: begin
              if (cmd_len == '0) begin
                s1_valid_nxt = 1'b1;
              end else begin
                state_nxt   = ST_SHIFT;
                sh_res_nxt  = cmd_ctl.res;
                src_nxt     = next_slot(cmd_addr);
                dst_nxt     = cmd_addr;
                rd_left_nxt = cmd_len;
                wr_left_nxt = cmd_len;
              end
            end
            default: begin
              s1_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // read one slot ahead while the previous value is written back
        if (rd_left_r != '0) begin
          mem_re      = 1'b1;
          mem_ra      = src_r;
          src_nxt     = next_slot(src_r);
          rd_left_nxt = rd_left_r - CNT_W'(1);
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          mem_we      = 1'b1;
          mem_wa      = dst_r;
          mem_wd      = mem_q_r;
          dst_nxt     = next_slot(dst_r);
          wr_left_nxt = wr_left_r - CNT_W'(1);
          if (wr_left_r == CNT_W'(1)) begin
            state_nxt    = ST_IDLE;
            s1_valid_nxt = 1'b1;
            s1_res_nxt   = sh_res_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_valid_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= s1_valid_nxt;
      pend_r     <= pend_nxt;
    end
    s1_res_r  <= s1_res_nxt;
    s1_rd_r   <= s1_rd_nxt;
    sh_res_r  <= sh_res_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    rd_left_r <= rd_left_nxt;
    wr_left_r <= wr_left_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= store_mem[mem_ra];
    end
  end

endmodule

[hw/rtl/iqr_checker.sv]
// ----------------------------------------------------------------------------
// iqr_checker
// Port-level checks of the indexed queue over time, bound to the top level.
// ----------------------------------------------------------------------------
module iqr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic                          out_ok,
  input logic [iqr_pkg::VALUE_W-1:0]   out_data_out,
  input logic [iqr_pkg::COUNT_W-1:0]   out_entry_count_now
);

  import iqr_pkg::*;

  logic               have_prev_r;
  logic [COUNT_W-1:0] prev_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (pop && !empty) begin
      have_prev_r <= 1'b1;
    end
    if (pop && !empty) begin
      prev_cnt_r <= out_entry_count_now;
    end
  end

  // reset leaves no result waiting and room for requests
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queue not idle after reset");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_ok) |-> (out_data_out == '0))
    else $error("failed request returned data");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_ok) && $stable(out_data_out)
                          && $stable(out_entry_count_now)))
    else $error("waiting result changed");

  // count moves by at most one per request, or drops to zero on clear
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && have_prev_r) |->
      (out_entry_count_now == prev_cnt_r ||
       out_entry_count_now == prev_cnt_r + COUNT_W'(1) ||
       out_entry_count_now == prev_cnt_r - COUNT_W'(1) ||
       out_entry_count_now == '0))
    else $error("count jumped between results");

endmodule

bind indexed_queue_with_removal iqr_checker u_iqr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .push                (push),
  .full                (full),
  .empty               (empty),
  .pop                 (pop),
  .out_ok              (out_ok),
  .out_data_out        (out_data_out),
  .out_entry_count_now (out_entry_count_now)
);
